// File: hdl/rrd_pkg.sv
`timescale 1ns / 1ps
package rrd_pkg;

  // Receive ring geometry (power of two)
  localparam int unsigned RING_BYTES = 32768;
  localparam int unsigned OFFSET_W   = $clog2(RING_BYTES);

  // Field widths
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned PTR_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SKIP_W  = 4;
  localparam int unsigned END_W   = ((OFFSET_W > LEN_W) ? OFFSET_W : LEN_W) + 1;
  localparam int unsigned SPAN_W  = LEN_W + 1;

  // Header and trailer sizes
  localparam logic [LEN_W-1:0] HDR_BYTES    = LEN_W'(4);
  localparam logic [LEN_W-1:0] TRAIL_ROUND  = LEN_W'(7);
  localparam logic [PTR_W-1:0] PTR_BACKOFF  = PTR_W'(16);

  // Configuration reset values
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(18);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1522);

  // Configuration register indexes
  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_HDR3 = 3'd3,
    PH_DATA = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    logic              last;
    logic [LEN_W-1:0]  fbytes;
    logic [PTR_W-1:0]  rptr;
    logic [CNT_W-1:0]  good;
    logic [CNT_W-1:0]  bad;
  } result_t;

endpackage

// File: hdl/rrd_out_buf.sv
`timescale 1ns / 1ps
module rrd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rrd_pkg::result_t din,
  output logic             out_valid,
  input  logic             out_stall,
  output rrd_pkg::result_t dout,
  output logic             full
);
  import rrd_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // Advance the output register, park a result in the skid stage when blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        dout       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (!out_valid || take) begin
        dout      <= din;
        out_valid <= 1'b1;
      end else begin
        skid       <= din;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Skid stage only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a request while output is empty");

  // A parked request stays until the output drains
  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> skid_valid)
    else $error("parked request lost under stall");

  // A load is never taken while the skid stage is occupied
  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !take) |=> (skid_valid && $stable(skid)))
    else $error("skid stage overwritten");

endmodule

// File: hdl/rx_ring_record_deframer_unit.sv
`timescale 1ns / 1ps
// Receive ring deframer: takes one ring byte per cycle while in_stall is low and parses
// 4-byte headers (status LE, length LE), giving one result per payload byte, one "record done"
// result with the new read pointer on the record's last byte, and one "bad header" result on a
// rejected header. The parser state updates in a single pass and each result lands in an
// output register backed by a one-entry skid stage, so in_stall rises only when a second
// result waits behind a stalled output. Length limits are set through the APB port (min at
// 0x0, max at 0x4); the user must write them only while idle, which the block does not enforce.
module rx_ring_record_deframer_unit (
  input  logic                      clk,
  input  logic                      rst,
  // APB configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Ring byte stream
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                ring_byte,
  // Results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                result_kind,
  output logic [7:0]                payload_byte,
  output logic                      last_payload,
  output logic [rrd_pkg::LEN_W-1:0] frame_bytes,
  output logic [rrd_pkg::PTR_W-1:0] read_pointer,
  output logic [rrd_pkg::CNT_W-1:0] good_frames,
  output logic [rrd_pkg::CNT_W-1:0] bad_headers
);
  import rrd_pkg::*;

  // Configuration
  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] max_len;

  // Parser state
  phase_t              phase;
  phase_t              phase_next;
  logic [LEN_W-1:0]    byte_count;
  logic [OFFSET_W-1:0] ring_offset;
  logic [OFFSET_W-1:0] next_offset;
  logic [7:0]          status_low;
  logic [7:0]          len_low;
  logic [LEN_W-1:0]    frame_len;
  logic [SKIP_W-1:0]   skip_len;
  logic [CNT_W-1:0]    good_count;
  logic [CNT_W-1:0]    error_count;

  logic                accept;
  logic [15:0]         hdr_len;
  logic [LEN_W-1:0]    hdr_len11;
  logic                hdr_good;
  logic [LEN_W-1:0]    hdr_plen;
  logic [SPAN_W-1:0]   hdr_span;
  logic [SKIP_W-1:0]   hdr_skip;
  logic [END_W-1:0]    hdr_end;
  logic [OFFSET_W-1:0] hdr_next;
  logic [LEN_W-1:0]    plen;
  logic [LEN_W-1:0]    count_inc;
  logic                data_last;
  logic                skip_done;
  logic                hdr_finish;
  logic [PTR_W-1:0]    rptr_hdr;
  logic [PTR_W-1:0]    rptr_rec;
  logic [CNT_W-1:0]    good_inc;
  logic [CNT_W-1:0]    error_inc;

  logic                res_valid;
  result_t             res;
  result_t             out_res;
  logic                buf_full;

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MIN_LEN: min_len <= pwdata[LEN_W-1:0];
        REG_MAX_LEN: max_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_LEN: prdata = 32'(min_len);
      REG_MAX_LEN: prdata = 32'(max_len);
      default:     prdata = '0;
    endcase
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // Header decode on the fourth header byte
  assign hdr_len   = {ring_byte, len_low};
  assign hdr_len11 = hdr_len[LEN_W-1:0];
  assign hdr_good  = status_low[0] && (hdr_len >= 16'(min_len)) && (hdr_len <= 16'(max_len));
  assign hdr_plen  = (hdr_len11 > HDR_BYTES) ? (hdr_len11 - HDR_BYTES) : '0;
  // Bytes from header end to the aligned record end, less the payload
  assign hdr_span  = (SPAN_W'(ring_offset[1:0]) + SPAN_W'(hdr_len11) + SPAN_W'(TRAIL_ROUND))
                     & ~SPAN_W'(3);
  assign hdr_skip  = SKIP_W'(hdr_span - SPAN_W'(HDR_BYTES) - SPAN_W'(hdr_plen));
  assign hdr_end   = (END_W'(ring_offset) + END_W'(hdr_len11) + END_W'(TRAIL_ROUND))
                     & ~END_W'(3);
  assign hdr_next  = hdr_end[OFFSET_W-1:0];
  assign hdr_finish = (hdr_plen == '0) && (hdr_skip == '0);

  assign rptr_hdr  = PTR_W'(hdr_next) - PTR_BACKOFF;
  assign rptr_rec  = PTR_W'(next_offset) - PTR_BACKOFF;

  // Body progress
  assign plen      = (frame_len > HDR_BYTES) ? (frame_len - HDR_BYTES) : '0;
  assign count_inc = byte_count + LEN_W'(1);
  assign data_last = count_inc >= plen;
  assign skip_done = count_inc >= LEN_W'(skip_len);

  assign good_inc  = good_count + CNT_W'(1);
  assign error_inc = error_count + CNT_W'(1);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HDR0: phase_next = PH_HDR1;
      PH_HDR1: phase_next = PH_HDR2;
      PH_HDR2: phase_next = PH_HDR3;
      PH_HDR3: begin
        if (!hdr_good)            phase_next = PH_HDR0;
        else if (hdr_plen != '0)  phase_next = PH_DATA;
        else if (hdr_finish)      phase_next = PH_HDR0;
        else                      phase_next = PH_SKIP;
      end
      PH_DATA: if (data_last) phase_next = PH_SKIP;
      PH_SKIP: if (skip_done) phase_next = PH_HDR0;
      default: phase_next = PH_HDR0;
    endcase
  end

  // Result for the byte at hand
  always_comb begin
    res_valid  = 1'b0;
    res.kind   = KIND_PAYLOAD;
    res.data   = '0;
    res.last   = 1'b0;
    res.fbytes = '0;
    res.rptr   = '0;
    res.good   = good_count;
    res.bad    = error_count;
    case (phase)
      PH_HDR3: begin
        if (!hdr_good) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD;
          res.bad   = error_inc;
        end else if (hdr_finish) begin
          res_valid  = 1'b1;
          res.kind   = KIND_DONE;
          res.rptr   = rptr_hdr;
          res.good   = good_inc;
        end
      end
      PH_DATA: begin
        res_valid  = 1'b1;
        res.kind   = KIND_PAYLOAD;
        res.data   = ring_byte;
        res.last   = data_last;
        res.fbytes = plen;
      end
      PH_SKIP: begin
        if (skip_done) begin
          res_valid  = 1'b1;
          res.kind   = KIND_DONE;
          res.fbytes = plen;
          res.rptr   = rptr_rec;
          res.good   = good_inc;
        end
      end
      default: ;
    endcase
  end

  // Update parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      byte_count  <= '0;
      ring_offset <= '0;
      next_offset <= '0;
      status_low  <= '0;
      len_low     <= '0;
      frame_len   <= '0;
      skip_len    <= '0;
      good_count  <= '0;
      error_count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      case (phase)
        PH_HDR0: status_low <= ring_byte;
        PH_HDR2: len_low    <= ring_byte;
        PH_HDR3: begin
          byte_count <= '0;
          if (!hdr_good) begin
            error_count <= error_inc;
            ring_offset <= '0;
          end else begin
            frame_len   <= hdr_len11;
            skip_len    <= hdr_skip;
            next_offset <= hdr_next;
            if (hdr_finish) begin
              good_count  <= good_inc;
              ring_offset <= hdr_next;
            end
          end
        end
        PH_DATA: byte_count <= data_last ? '0 : count_inc;
        PH_SKIP: begin
          if (skip_done) begin
            byte_count  <= '0;
            good_count  <= good_inc;
            ring_offset <= next_offset;
          end else begin
            byte_count <= count_inc;
          end
        end
        default: ;
      endcase
    end
  end

  rrd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .din       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (out_res),
    .full      (buf_full)
  );

  assign result_kind  = out_res.kind;
  assign payload_byte = out_res.data;
  assign last_payload = out_res.last;
  assign frame_bytes  = out_res.fbytes;
  assign read_pointer = out_res.rptr;
  assign good_frames  = out_res.good;
  assign bad_headers  = out_res.bad;

  // Payload phase only runs with a nonempty payload, and the count stays below it
  a_data_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (plen != '0 && byte_count < plen))
    else $error("payload count out of range");

  // Skip phase always has at least one byte left to drop
  a_skip_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip_len != '0 && byte_count < LEN_W'(skip_len)))
    else $error("skip count out of range");

  // A rejected header bumps the error count and restarts at offset zero
  a_bad_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_HDR3 && !hdr_good) |=>
      (phase == PH_HDR0 && ring_offset == '0 && error_count == $past(error_inc)))
    else $error("bad header did not restart parsing");

endmodule
